/* hdl/gsv_pkg.sv */
// Shared types and constants for the gamepad stick to velocity unit.
// Holds event codes, stream field widths and the divider status struct.
// No dependencies.
package gsv_pkg;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_AXIS  = 2'd1;
  localparam logic [1:0] MODE_DROP  = 2'd2;
  localparam logic [1:0] MODE_OTHER = 2'd3;

  localparam logic [5:0] AXIS_LX = 6'd0;
  localparam logic [5:0] AXIS_LY = 6'd1;
  localparam logic [5:0] AXIS_RX = 6'd2;
  localparam logic [5:0] AXIS_RY = 6'd5;

  localparam logic [1:0] SLOT_LX = 2'd0;
  localparam logic [1:0] SLOT_LY = 2'd1;
  localparam logic [1:0] SLOT_RX = 2'd2;
  localparam logic [1:0] SLOT_RY = 2'd3;

  localparam logic [15:0] RAW_MIN_RST = 16'd0;
  localparam logic [15:0] RAW_MAX_RST = 16'd255;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

/* hdl/gsv_sdiv.sv */
// Shared serial divider: rounds mag*ONE/divisor to nearest, one quotient bit a cycle.
// Flags saturation when the quotient reaches 2^FRAC_BITS.
// Depends on gsv_pkg.
module gsv_sdiv #(
  parameter int FRAC_BITS = 15,
  parameter int MW        = 17,
  parameter int DW        = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [MW-1:0]          mag,
  input  logic [DW-1:0]          dvs,
  output gsv_pkg::div_stat_t     stat,
  output logic [FRAC_BITS-1:0]   quo
);
  import gsv_pkg::*;

  localparam int XW = MW + FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_CHK  = 2'd2;
  localparam logic [1:0] D_RUN  = 2'd3;

  logic [1:0]           state;
  logic [MW-1:0]        mag_q;
  logic [DW-1:0]        dvs_q;
  logic [XW-1:0]        x;
  logic [DW-1:0]        rem;
  logic [FRAC_BITS-1:0] dvd;
  logic [CW-1:0]        cnt;
  logic                 done;
  logic                 sat;
  logic [DW:0]          t;
  logic [DW:0]          diff;
  logic                 ge;
  logic [MW:0]          hi;

  always_comb begin
    t    = {rem, dvd[FRAC_BITS-1]};
    diff = t - {1'b0, dvs_q};
    ge   = (t >= {1'b0, dvs_q});
    hi   = x[XW-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      sat   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            mag_q <= mag;
            dvs_q <= dvs;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          x     <= (XW'(mag_q) << FRAC_BITS) - XW'(mag_q) + XW'(dvs_q >> 1);
          state <= D_CHK;
        end
        D_CHK: begin
          if (hi >= (MW + 1)'(dvs_q)) begin
            sat   <= 1'b1;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            sat   <= 1'b0;
            rem   <= x[FRAC_BITS +: DW];
            dvd   <= x[FRAC_BITS-1:0];
            cnt   <= CW'(FRAC_BITS);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[DW-1:0] : t[DW-1:0];
          quo <= {quo[FRAC_BITS-2:0], ge};
          dvd <= dvd << 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.sat  = sat;

endmodule

/* hdl/gamepad_stick_to_velocity_unit.sv */
// Top level of the gamepad stick to velocity unit: event sequencer, stick store, output beat.
// Depends on gsv_pkg and gsv_sdiv.
//
// Input beats carry one gamepad event: tuser = mode and axis code, tdata = raw reading.
// A stick axis event is normalised against its configured raw range, passed through a
// fixed dead zone and stored; one output beat then reports this axis, all four sticks,
// linear speed (-left Y) and angular speed (1.5 * right X). A sync-dropped event clears
// the sticks and gives a beat with every value zero and the dropped flag set. Key, hat,
// unknown-axis and other events are consumed with no output beat.
// The raw ranges are written through cfg_we/cfg_index/cfg_data, index 2k = min and
// 2k+1 = max of stick k (left X, left Y, right X, right Y). The user must write them
// only while the unit is idle; the unit itself does not enforce this. A stick event
// makes up to two passes through the shared serial divider, one quotient bit per
// cycle each. s_axis_tready is high only between events.
// The output beat sits in a register; a stalled receiver holds it, and the next event
// is still taken but waits at the end of its work until the register frees.
// Reset (rst, synchronous) clears the sticks, empties the output and restores the
// ranges to 0..255.
module gamepad_stick_to_velocity_unit #(
  parameter int FRAC_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] raw_value
  input  logic [gsv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] mode, [7:2] axis_code
  input  logic [gsv_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] axis_value, [31:16] left_x, [47:32] left_y, [63:48] right_x,
  // [79:64] right_y, [95:80] linear_speed, [112:96] angular_speed, [119:113] zero
  output logic [gsv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] dropped
  output logic [gsv_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [gsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gsv_pkg::*;

  localparam int ONE_I = (1 << FRAC_BITS) - 1;
  localparam int DZ_I  = (ONE_I * 8 + 50) / 100;
  localparam int MW    = (FRAC_BITS > 17) ? FRAC_BITS : 17;
  localparam int DW    = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int SW    = FRAC_BITS + 1;
  localparam int AW    = SW + 2;

  localparam logic [FRAC_BITS-1:0] ONE    = FRAC_BITS'(ONE_I);
  localparam logic [FRAC_BITS-1:0] DZ     = FRAC_BITS'(DZ_I);
  localparam logic [DW-1:0]        DZ_DVS = DW'(ONE_I - DZ_I);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_WAIT0 = 3'd2;
  localparam logic [2:0] S_DZ    = 3'd3;
  localparam logic [2:0] S_WAIT1 = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                  state;
  logic [15:0]                 cfg_min [4];
  logic [15:0]                 cfg_max [4];
  logic signed [SW-1:0]        stick [4];
  logic [1:0]                  slot;
  logic signed [15:0]          raw;
  logic                        neg;
  logic [FRAC_BITS-1:0]        a;
  logic [FRAC_BITS-1:0]        y;
  logic signed [SW-1:0]        axis_val;
  logic                        drop;

  logic signed [17:0]          num;
  logic signed [16:0]          den;
  logic [17:0]                 num_abs;
  logic [16:0]                 den_abs;
  logic                        start;
  logic [MW-1:0]               mag_in;
  logic [DW-1:0]               dvs_in;
  div_stat_t                   stat;
  logic [FRAC_BITS-1:0]        quo;
  logic signed [SW-1:0]        val;
  logic                        out_free;
  logic [SW-1:0]               rx_abs;
  logic [AW-1:0]               ang_mag;
  logic signed [AW-1:0]        ang;
  logic signed [SW:0]          lin;
  logic                        accept;
  logic [1:0]                  in_mode;
  logic [5:0]                  in_code;

  assign in_mode       = s_axis_tuser[1:0];
  assign in_code       = s_axis_tuser[7:2];
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    num     = (18'(signed'(raw)) <<< 1) - 18'(signed'(cfg_min[slot]))
              - 18'(signed'(cfg_max[slot]));
    den     = 17'(signed'(cfg_max[slot])) - 17'(signed'(cfg_min[slot]));
    num_abs = num[17] ? 18'(-num) : 18'(num);
    den_abs = den[16] ? 17'(-den) : 17'(den);
    start   = 1'b0;
    mag_in  = MW'(num_abs[16:0]);
    dvs_in  = DW'(den_abs[15:0]);
    if (state == S_NORM) begin
      start = (den != 17'sd0);
    end else if (state == S_DZ) begin
      start  = (a >= DZ);
      mag_in = MW'(a - DZ);
      dvs_in = DZ_DVS;
    end
    val = neg ? -signed'(SW'(y)) : signed'(SW'(y));
  end

  always_comb begin
    rx_abs  = stick[SLOT_RX][SW-1] ? SW'(-stick[SLOT_RX]) : SW'(stick[SLOT_RX]);
    ang_mag = ((AW'(rx_abs) << 1) + AW'(rx_abs) + AW'(1)) >> 1;
    ang     = stick[SLOT_RX][SW-1] ? -signed'(ang_mag) : signed'(ang_mag);
    lin     = -(SW + 1)'(stick[SLOT_LY]);
  end

  gsv_sdiv #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW),
    .DW        (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag_in),
    .dvs   (dvs_in),
    .stat  (stat),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cfg_min[i] <= RAW_MIN_RST;
        cfg_max[i] <= RAW_MAX_RST;
      end
    end else if (cfg_we) begin
      if (cfg_index[0]) begin
        cfg_max[cfg_index[2:1]] <= cfg_data;
      end else begin
        cfg_min[cfg_index[2:1]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        stick[i] <= '0;
      end
    end else begin
      if (state == S_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            raw <= signed'(s_axis_tdata);
            if (in_mode == MODE_DROP) begin
              for (int i = 0; i < 4; i++) begin
                stick[i] <= '0;
              end
              axis_val <= '0;
              drop     <= 1'b1;
              state    <= S_EMIT;
            end else if (in_mode == MODE_AXIS) begin
              drop <= 1'b0;
              unique case (in_code)
                AXIS_LX: begin slot <= SLOT_LX; state <= S_NORM; end
                AXIS_LY: begin slot <= SLOT_LY; state <= S_NORM; end
                AXIS_RX: begin slot <= SLOT_RX; state <= S_NORM; end
                AXIS_RY: begin slot <= SLOT_RY; state <= S_NORM; end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        S_NORM: begin
          neg <= num[17] ^ den[16];
          if (den == 17'sd0) begin
            a     <= '0;
            state <= S_DZ;
          end else begin
            state <= S_WAIT0;
          end
        end
        S_WAIT0: begin
          if (stat.done) begin
            a     <= stat.sat ? ONE : quo;
            state <= S_DZ;
          end
        end
        S_DZ: begin
          if (a < DZ) begin
            y     <= '0;
            state <= S_STORE;
          end else begin
            state <= S_WAIT1;
          end
        end
        S_WAIT1: begin
          if (stat.done) begin
            y     <= quo;
            state <= S_STORE;
          end
        end
        S_STORE: begin
          stick[slot] <= val;
          axis_val    <= val;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_axis_tdata <= {7'd0, 17'(ang), 16'(lin), 16'(stick[SLOT_RY]), 16'(stick[SLOT_RX]),
                       16'(stick[SLOT_LY]), 16'(stick[SLOT_LX]), 16'(axis_val)};
      m_axis_tuser <= drop;
    end
  end

endmodule

/* hdl/gsv_chk.sv */
// Port-level checker for the gamepad stick to velocity unit, with its bind.
// Depends on gsv_pkg and gamepad_stick_to_velocity_unit.
module gsv_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [gsv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic [gsv_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gsv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [gsv_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import gsv_pkg::*;

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("dropped beat carries non-zero values");

  a_linear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[95:80] == 16'(-m_axis_tdata[47:32]))
    else $error("linear speed is not the negated left vertical");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == MODE_AXIS
      && s_axis_tuser[7:2] == AXIS_LX |=> !s_axis_tready)
    else $error("stick event did not hold off the next beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

endmodule

bind gamepad_stick_to_velocity_unit gsv_chk u_chk (.*);

/* bench/gsv_checker.sv */
// Checker for the gamepad stick to velocity unit: watches the event, result and
// register-write channels, predicts each result beat and compares it field by field.
// Depends on gsv_pkg.
module gsv_checker #(
  parameter int FRAC_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [gsv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [gsv_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [gsv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic [gsv_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [gsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsv_pkg::*;

  localparam longint ONE  = (longint'(1) << FRAC_BITS) - 1;
  localparam longint DEAD = (ONE * 8 + 50) / 100;

  typedef struct packed {
    logic [15:0] axis_value;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] linear_speed;
    logic [16:0] angular_speed;
    logic        dropped;
  } velocity_beat_t;

  logic [15:0]    raw_range [8];
  longint         stick [4];
  velocity_beat_t expected_beats [$];
  int             fail_count = 0;

  function automatic longint round_div(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint condition_raw(longint v, longint lo, longint hi);
    longint num, den, n, a, y;
    num = 2 * v - lo - hi;
    den = hi - lo;
    if (den == 0) return 0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    n = round_div(num * ONE, den);
    if (n > ONE) n = ONE;
    if (n < -ONE) n = -ONE;
    a = (n < 0) ? -n : n;
    if (a < DEAD) return 0;
    y = round_div((a - DEAD) * ONE, ONE - DEAD);
    return (n < 0) ? -y : y;
  endfunction

  function automatic velocity_beat_t velocity_beat(longint axis, logic drop);
    velocity_beat_t b;
    b.axis_value    = 16'(axis);
    b.left_x        = 16'(stick[0]);
    b.left_y        = 16'(stick[1]);
    b.right_x       = 16'(stick[2]);
    b.right_y       = 16'(stick[3]);
    b.linear_speed  = 16'(-stick[1]);
    b.angular_speed = 17'(round_div(3 * stick[2], 2));
    b.dropped       = drop;
    return b;
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    logic [1:0]     kind;
    logic [5:0]     code;
    logic [1:0]     slot;
    logic           hit;
    longint         v;
    velocity_beat_t got, want;
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        raw_range[2 * k]     = RAW_MIN_RST;
        raw_range[2 * k + 1] = RAW_MAX_RST;
        stick[k]             = 0;
      end
      expected_beats.delete();
    end else begin
      if (cfg_we) raw_range[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        kind = s_axis_tuser[1:0];
        code = s_axis_tuser[7:2];
        hit  = 1'b1;
        slot = SLOT_LX;
        case (code)
          AXIS_LX: slot = SLOT_LX;
          AXIS_LY: slot = SLOT_LY;
          AXIS_RX: slot = SLOT_RX;
          AXIS_RY: slot = SLOT_RY;
          default: hit = 1'b0;
        endcase
        if (kind == MODE_DROP) begin
          for (int k = 0; k < 4; k++) stick[k] = 0;
          expected_beats.push_back(velocity_beat(0, 1'b1));
        end else if (kind == MODE_AXIS && hit) begin
          v = condition_raw(longint'($signed(s_axis_tdata)),
                            longint'($signed(raw_range[{slot, 1'b0}])),
                            longint'($signed(raw_range[{slot, 1'b1}])));
          stick[slot] = v;
          expected_beats.push_back(velocity_beat(v, 1'b0));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.axis_value    = m_axis_tdata[15:0];
        got.left_x        = m_axis_tdata[31:16];
        got.left_y        = m_axis_tdata[47:32];
        got.right_x       = m_axis_tdata[63:48];
        got.right_y       = m_axis_tdata[79:64];
        got.linear_speed  = m_axis_tdata[95:80];
        got.angular_speed = m_axis_tdata[112:96];
        got.dropped       = m_axis_tuser[0];
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, got);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("axis_value", want.axis_value, got.axis_value);
          check_field("left_x", want.left_x, got.left_x);
          check_field("left_y", want.left_y, got.left_y);
          check_field("right_x", want.right_x, got.right_x);
          check_field("right_y", want.right_y, got.right_y);
          check_field("linear_speed", want.linear_speed, got.linear_speed);
          check_field("angular_speed", want.angular_speed, got.angular_speed);
          check_field("dropped", want.dropped, got.dropped);
        end
      end
    end
    pending <= expected_beats.size();
    errors  <= fail_count;
  end

endmodule

/* bench/tb_top.sv */
// Top of the testbench for the gamepad stick to velocity unit: clock, reset, event
// stimulus, receiver stalls, range settings, watchdog and verdict.
// Depends on gsv_pkg, gamepad_stick_to_velocity_unit and gsv_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsv_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_RESULTS  = 240;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          errors;
  int          pending;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          quiet_run = 0;
  logic [15:0] range_lo [4];
  logic [15:0] range_hi [4];
  int          n_stick = 0;
  int          n_drop = 0;
  int          n_ignored = 0;
  int          n_settings = 0;

  gamepad_stick_to_velocity_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  gsv_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [5:0] axis_of(logic [1:0] slot);
    case (slot)
      SLOT_LX: return AXIS_LX;
      SLOT_LY: return AXIS_LY;
      SLOT_RX: return AXIS_RX;
      default: return AXIS_RY;
    endcase
  endfunction

  function automatic logic [15:0] pick_raw(logic [1:0] slot);
    int lo, hi, a, b, mid, off;
    lo  = int'($signed(range_lo[slot]));
    hi  = int'($signed(range_hi[slot]));
    a   = (lo < hi) ? lo : hi;
    b   = (lo < hi) ? hi : lo;
    mid = (a + b) / 2;
    off = ((b - a) * 2621) / 65534 + int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0: return 16'(a);
      1: return 16'(b);
      2: return 16'(mid + off);
      3: return 16'(mid - off);
      4, 5: return 16'($urandom);
      default: return 16'(a + int'($urandom_range(0, b - a)));
    endcase
  endfunction

  task automatic offer(logic [1:0] kind, logic [5:0] code, logic [15:0] raw);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {code, kind};
    s_axis_tdata  <= raw;
    do @(posedge clk); while (!s_axis_tready);
    if (kind == MODE_DROP) n_drop++;
    else if (kind == MODE_AXIS && (code == AXIS_LX || code == AXIS_LY ||
                                   code == AXIS_RX || code == AXIS_RY)) n_stick++;
    else n_ignored++;
    if (quiet_run > 0) begin
      quiet_run--;
    end else if ($urandom_range(0, 29) == 0) begin
      quiet_run = $urandom_range(10, 40);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_ranges();
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= {2'(k), 1'b0};
      cfg_data  <= range_lo[k];
      @(posedge clk);
      cfg_index <= {2'(k), 1'b1};
      cfg_data  <= range_hi[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic shuffle_ranges();
    int lo, hi;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 4))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin
          lo = $urandom;
          hi = lo + int'($urandom_range(1, 8));
        end
        2: begin
          lo = -int'($urandom_range(0, 32768));
          hi = $urandom_range(0, 32767);
        end
        3: begin
          lo = $urandom_range(0, 32767);
          hi = -int'($urandom_range(0, 32768));
        end
        default: begin
          lo = $urandom;
          hi = lo;
        end
      endcase
      range_lo[k] = 16'(lo);
      range_hi[k] = 16'(hi);
    end
    load_ranges();
  endtask

  task automatic random_event();
    logic [1:0] slot;
    int         r;
    slot = 2'($urandom_range(0, 3));
    r    = $urandom_range(0, 99);
    if (r < 72) offer(MODE_AXIS, axis_of(slot), pick_raw(slot));
    else if (r < 80) offer(MODE_DROP, 6'($urandom), 16'($urandom));
    else if (r < 88) offer(MODE_AXIS, 6'($urandom), 16'($urandom));
    else if (r < 92) offer(MODE_KEY, 6'($urandom), 16'($urandom));
    else if (r < 95) offer(MODE_OTHER, 6'($urandom), 16'($urandom));
    else offer(MODE_AXIS, 6'(16 + $urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic random_phase(int goal);
    while (n_stick + n_drop < goal) random_event();
    drain();
  endtask

  initial begin : receiver
    int r;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_on) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end else if (r == 3) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(30, 200)) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int goal;
    for (int k = 0; k < 4; k++) begin
      range_lo[k] = RAW_MIN_RST;
      range_hi[k] = RAW_MAX_RST;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(MODE_AXIS, AXIS_LX, 16'd0);
    offer(MODE_AXIS, AXIS_LX, 16'd255);
    offer(MODE_AXIS, AXIS_LY, 16'd128);
    offer(MODE_AXIS, AXIS_RX, 16'h8000);
    offer(MODE_AXIS, AXIS_RY, 16'h7fff);
    offer(MODE_AXIS, AXIS_RX, 16'd200);
    offer(MODE_KEY, AXIS_LX, 16'd100);
    offer(MODE_OTHER, AXIS_LY, 16'hffff);
    offer(MODE_AXIS, 6'd16, 16'd1);
    offer(MODE_AXIS, 6'd17, 16'hffff);
    offer(MODE_AXIS, 6'd63, 16'd50);
    offer(MODE_AXIS, 6'd3, 16'd50);
    offer(MODE_DROP, 6'h3f, 16'h5a5a);
    offer(MODE_AXIS, AXIS_LY, 16'd10);
    drain();

    range_lo[SLOT_LX] = 16'h8001;
    range_hi[SLOT_LX] = 16'h7fff;
    range_lo[SLOT_LY] = 16'd1234;
    range_hi[SLOT_LY] = 16'd1234;
    range_lo[SLOT_RX] = 16'd255;
    range_hi[SLOT_RX] = 16'd0;
    range_lo[SLOT_RY] = 16'h8000;
    range_hi[SLOT_RY] = 16'h7fff;
    load_ranges();
    offer(MODE_AXIS, AXIS_LX, 16'd2620);
    offer(MODE_AXIS, AXIS_LX, 16'd2621);
    offer(MODE_AXIS, AXIS_LX, 16'd2622);
    offer(MODE_AXIS, AXIS_LX, 16'(-2621));
    offer(MODE_AXIS, AXIS_LX, 16'h8000);
    offer(MODE_AXIS, AXIS_LY, 16'd5000);
    offer(MODE_AXIS, AXIS_RX, 16'd0);
    offer(MODE_AXIS, AXIS_RY, 16'h8000);
    offer(MODE_AXIS, AXIS_RY, 16'h7fff);
    offer(MODE_DROP, 6'd0, 16'd0);
    drain();

    goal = n_stick + n_drop;
    for (int k = 0; k < 4; k++) begin
      range_lo[k] = RAW_MIN_RST;
      range_hi[k] = RAW_MAX_RST;
    end
    load_ranges();
    goal += PHASE_RESULTS;
    random_phase(goal);

    for (int k = 0; k < 4; k++) begin
      range_lo[k] = 16'h8000;
      range_hi[k] = 16'h7fff;
    end
    load_ranges();
    hold_req = 1'b1;
    goal += PHASE_RESULTS;
    random_phase(goal);

    shuffle_ranges();
    goal += PHASE_RESULTS;
    random_phase(goal);

    range_lo[SLOT_LX] = 16'h7fff;
    range_hi[SLOT_LX] = 16'h8000;
    range_lo[SLOT_LY] = 16'h8000;
    range_hi[SLOT_LY] = 16'h8000;
    range_lo[SLOT_RX] = 16'h8000;
    range_hi[SLOT_RX] = 16'h8001;
    range_lo[SLOT_RY] = 16'd0;
    range_hi[SLOT_RY] = 16'd255;
    load_ranges();
    goal += PHASE_RESULTS;
    random_phase(goal);

    shuffle_ranges();
    goal += PHASE_RESULTS;
    random_phase(goal);

    idle_on = 1'b0;
    shuffle_ranges();
    goal += PHASE_RESULTS;
    random_phase(goal);

    $display("covered %0d stick events, %0d sync drops and %0d ignored events",
             n_stick, n_drop, n_ignored);
    $display("across %0d range settings, with idling on both sides and one long stall",
             n_settings);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
hdl/gsv_pkg.sv
hdl/gsv_sdiv.sv
hdl/gamepad_stick_to_velocity_unit.sv
hdl/gsv_chk.sv
bench/gsv_checker.sv
bench/tb_top.sv
